// File: sv/ptsch_pkg.sv
`default_nettype none
package ptsch_pkg;

	localparam logic [31:0] MAX_SLEEP_RESET = 32'd100000;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_ADD      = 3'd1,
		OP_STOP     = 3'd2,
		OP_STOP_ALL = 3'd3,
		OP_PAUSE    = 3'd4,
		OP_RESUME   = 3'd5,
		OP_QUERY    = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		EV_FIRE    = 2'd0,
		EV_END     = 2'd1,
		EV_SUMMARY = 2'd2,
		EV_QUERY   = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SUMMARY
	} state_t;

	// single-cycle slot commands broadcast to the cell row
	typedef struct packed {
		logic add;
		logic stop;
		logic stop_all;
		logic pause;
		logic resume;
	} cmd_t;

	// per-slot marks reported by a cell
	typedef struct packed {
		logic active;
		logic pending;
		logic paused;
		logic stop_req;
	} slot_status_t;

endpackage
`default_nettype wire

// File: sv/ptsch_ifs.sv
`default_nettype none
interface ptsch_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [2:0]  slot;
	logic [31:0] now_us;
	logic [31:0] period_us;
	logic        shutdown;

	modport source (output valid, opcode, slot, now_us, period_us, shutdown, input ready);
	modport sink (input valid, opcode, slot, now_us, period_us, shutdown, output ready);
endinterface

interface ptsch_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [2:0]  event_slot;
	logic [31:0] deadline_us;
	logic        found;
	logic        last;

	modport source (output valid, event_kind, event_slot, deadline_us, found, last,
		input ready);
	modport sink (input valid, event_kind, event_slot, deadline_us, found, last,
		output ready);
endinterface
`default_nettype wire

// File: sv/periodic_timer_scheduler.sv
// Channel | Dir | Handshake         | Payload
// req     | in  | valid/ready       | opcode, slot, now_us, period_us, shutdown
// evt     | out | valid/ready       | event_kind, event_slot, deadline_us, found, last
// cfg     | in  | cfg_we, no ready  | cfg_data -> max_sleep_us
//
// Slot commands and query are handled without a walk; every request waits for a free output register.
// Tick and shutdown walk a row of NUM_TIMERS cells, one cell per cycle while no event
// waits on a full output register.
// The walk token freezes in place while a fire/end event cannot enter the output register.
// arst_n clears all slot marks, the FSM and the output valid; max_sleep_us resets to 100000.
`default_nettype none
module periodic_timer_scheduler import ptsch_pkg::*; #(
	parameter int NUM_TIMERS = 8,
	parameter int TIME_WIDTH = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	ptsch_req_if.sink       req,
	ptsch_evt_if.source     evt,
	input wire logic        cfg_we,
	input wire logic [31:0] cfg_data
);

	localparam int TW = TIME_WIDTH;
	localparam int N  = NUM_TIMERS;

	// FSM and walk control
	state_t        state_q, state_nx;
	logic          start_q, shut_q;
	logic [TW-1:0] now_q, seed_q;
	logic [31:0]   max_sleep_q;

	// output register
	logic          out_valid_q;
	event_kind_t   kind_q;
	logic [2:0]    slot_q;
	logic [31:0]   dl_out_q;
	logic          found_q, last_q;

	logic          accept, out_free, adv, start_walk;
	logic          load_ev, load_sum, load_qry;
	opcode_t       op;
	cmd_t          cmd;
	logic [TW-1:0] now_in, period_in, seed_nx;
	logic [TW:0]   seed_raw;

	// cell row wiring; tok[0]/best[0] feed cell 0
	logic [N:0]         tok;
	logic [TW-1:0]      best [N+1];
	logic [N-1:0]       sel, ev_fire, ev_end, act, busy_v, above;
	slot_status_t [N-1:0] st;

	logic          ev_any, ev_is_end, ev_last, qry_found;
	logic [2:0]    ev_slot;

	assign accept    = req.valid && req.ready;
	assign op        = opcode_t'(req.opcode);
	assign now_in    = TW'(req.now_us);
	assign period_in = TW'(req.period_us);
	assign out_free  = !out_valid_q || evt.ready;

	// seed of the running minimum: now + max sleep, saturating
	assign seed_raw = {1'b0, now_in} + {1'b0, TW'(max_sleep_q)};
	assign seed_nx  = seed_raw[TW] ? '1 : seed_raw[TW-1:0];

	assign start_walk = accept && ((op == OP_TICK) || ((op == OP_STOP_ALL) && req.shutdown));

	always_comb begin
		cmd.add      = accept && (op == OP_ADD);
		cmd.stop     = accept && (op == OP_STOP);
		cmd.stop_all = accept && (op == OP_STOP_ALL) && !req.shutdown;
		cmd.pause    = accept && (op == OP_PAUSE);
		cmd.resume   = accept && (op == OP_RESUME);
	end

	assign tok[0]  = start_q;
	assign best[0] = seed_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign sel[i]    = (32'(req.slot) == 32'(i));
		assign act[i]    = st[i].active;
		assign busy_v[i] = st[i].active | st[i].pending;

		// is any slot above this one still active (finds the last shutdown end event)
		if (i == N - 1) begin : g_top
			assign above[i] = 1'b0;
		end else begin : g_mid
			assign above[i] = above[i+1] | act[i+1];
		end

		ptsch_cell #(
			.TW(TW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.best_in (best[i]),
			.best_out(best[i+1]),
			.shut    (shut_q),
			.now     (now_q),
			.cmd     (cmd),
			.sel     (sel[i]),
			.period  (period_in),
			.ev_fire (ev_fire[i]),
			.ev_end  (ev_end[i]),
			.st      (st[i])
		);
	end

	// at most one cell holds the token, so the event mux is an OR
	always_comb begin
		ev_slot = '0;
		for (int i = 0; i < N; i++) begin
			if (ev_fire[i] || ev_end[i]) begin
				ev_slot = ev_slot | 3'(i);
			end
		end
	end

	assign ev_any    = |(ev_fire | ev_end);
	assign ev_is_end = |ev_end;
	assign ev_last   = shut_q && |(ev_end & ~above);
	assign qry_found = |(sel & busy_v);

	// the row moves unless an event is waiting on a full output register
	assign adv = !ev_any || out_free;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_walk) begin
					state_nx = ST_WALK;
				end
			end
			ST_WALK: begin
				if (tok[N]) begin
					state_nx = shut_q ? ST_IDLE : ST_SUMMARY;
				end
			end
			ST_SUMMARY: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
		endcase
	end

	// outputs of the FSM
	always_comb begin
		req.ready = 1'b0;
		load_ev   = 1'b0;
		load_sum  = 1'b0;
		load_qry  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = out_free;
				load_qry  = accept && (op == OP_QUERY);
			end
			ST_WALK: begin
				load_ev = ev_any && out_free;
			end
			ST_SUMMARY: begin
				load_sum = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			max_sleep_q <= MAX_SLEEP_RESET;
		end else begin
			state_q <= state_nx;
			if (start_walk) begin
				start_q <= 1'b1;
			end else if (adv) begin
				start_q <= 1'b0;
			end
			if (load_ev || load_sum || load_qry) begin
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				max_sleep_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			shut_q <= (op == OP_STOP_ALL);
			now_q  <= now_in;
			seed_q <= seed_nx;
		end
		if (load_ev) begin
			kind_q   <= ev_is_end ? EV_END : EV_FIRE;
			slot_q   <= ev_slot;
			dl_out_q <= '0;
			found_q  <= 1'b0;
			last_q   <= ev_last;
		end else if (load_sum) begin
			kind_q   <= EV_SUMMARY;
			slot_q   <= '0;
			dl_out_q <= 32'(best[N]);
			found_q  <= 1'b0;
			last_q   <= 1'b1;
		end else if (load_qry) begin
			kind_q   <= EV_QUERY;
			slot_q   <= req.slot;
			dl_out_q <= '0;
			found_q  <= qry_found;
			last_q   <= 1'b1;
		end
	end

	assign evt.valid       = out_valid_q;
	assign evt.event_kind  = kind_q;
	assign evt.event_slot  = slot_q;
	assign evt.deadline_us = dl_out_q;
	assign evt.found       = found_q;
	assign evt.last        = last_q;

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one walk token in the cell row");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tok[N:1] == '0))
		else $error("walk token left in the row while idle");

	a_event_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ev_any |-> (state_q == ST_WALK))
		else $error("cell event outside a walk");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ev_fire | ev_end))
		else $error("two cells raised an event at once");

	a_summary_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUMMARY) |-> (tok[N:0] == '0 || $past(tok[N])))
		else $error("summary reached with the walk unfinished");
`endif

endmodule
`default_nettype wire

// File: sv/ptsch_cell.sv
`default_nettype none
module ptsch_cell import ptsch_pkg::*; #(
	parameter int TW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          tok_in,
	output      logic          tok_out,
	input  wire logic [TW-1:0] best_in,
	output      logic [TW-1:0] best_out,
	input  wire logic          shut,
	input  wire logic [TW-1:0] now,
	input  wire cmd_t          cmd,
	input  wire logic          sel,
	input  wire logic [TW-1:0] period,
	output      logic          ev_fire,
	output      logic          ev_end,
	output      slot_status_t  st
);

	logic          active_q, pending_q, paused_q, stop_q, tok_q;
	logic [TW-1:0] dl_q, per_q, best_q;

	logic          busy, go, due, keep;
	logic [TW-1:0] dl_eff, sum1, sum2, upd, nd, best_nx;
	logic [TW:0]   raw1, raw2;

	always_comb begin
		busy   = active_q | pending_q;
		go     = tok_in & adv;
		// a pending slot is activated at this tick with its deadline at now
		dl_eff = pending_q ? now : dl_q;
		keep   = !shut && busy && !stop_q && !paused_q;
		due    = keep && (dl_eff <= now);

		raw1 = {1'b0, dl_eff} + {1'b0, per_q};
		raw2 = {1'b0, now} + {1'b0, per_q};
		sum1 = raw1[TW] ? '1 : raw1[TW-1:0];
		sum2 = raw2[TW] ? '1 : raw2[TW-1:0];
		upd  = (sum1 < now) ? sum2 : sum1;
		nd   = due ? upd : dl_eff;

		best_nx = (keep && (nd < best_in)) ? nd : best_in;

		ev_fire = tok_in && due;
		ev_end  = tok_in && (shut ? active_q : (busy && stop_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pending_q <= 1'b0;
			paused_q  <= 1'b0;
			stop_q    <= 1'b0;
			tok_q     <= 1'b0;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
			end
			if (go) begin
				if (shut || (busy && stop_q)) begin
					active_q  <= 1'b0;
					pending_q <= 1'b0;
					paused_q  <= 1'b0;
					stop_q    <= 1'b0;
				end else if (busy) begin
					active_q  <= 1'b1;
					pending_q <= 1'b0;
				end
			end else if (cmd.add && sel && !busy) begin
				pending_q <= 1'b1;
				active_q  <= 1'b0;
				paused_q  <= 1'b0;
				stop_q    <= 1'b0;
			end else if (busy) begin
				if ((cmd.stop && sel) || cmd.stop_all) begin
					stop_q <= 1'b1;
				end
				if (cmd.pause && sel) begin
					paused_q <= 1'b1;
				end else if (cmd.resume && sel) begin
					paused_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && busy && !shut) begin
			dl_q <= nd;
		end
		if (go) begin
			best_q <= best_nx;
		end
		if (cmd.add && sel && !busy) begin
			per_q <= period;
		end
	end

	assign tok_out     = tok_q;
	assign best_out    = best_q;
	assign st.active   = active_q;
	assign st.pending  = pending_q;
	assign st.paused   = paused_q;
	assign st.stop_req = stop_q;

endmodule
`default_nettype wire

// File: tb/ptsch_scoreboard.sv
`timescale 1ns / 1ps
module ptsch_scoreboard import ptsch_pkg::*; #(
	parameter int NUM_TIMERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ptsch_req_if        req,
	ptsch_evt_if        evt,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	output int          fail_cnt,
	output int          pending_cnt
);

	typedef struct packed {
		event_kind_t kind;
		logic [2:0]  slot;
		logic [31:0] deadline;
		logic        found;
		logic        last;
	} sched_event_t;

	// events still owed by the block, oldest first
	sched_event_t due_events[$];

	// shadow of the timer table
	logic [NUM_TIMERS-1:0] tm_active;
	logic [NUM_TIMERS-1:0] tm_pending;
	logic [NUM_TIMERS-1:0] tm_paused;
	logic [NUM_TIMERS-1:0] tm_stop;
	logic [31:0]           tm_deadline [NUM_TIMERS];
	logic [31:0]           tm_period [NUM_TIMERS];
	logic [31:0]           sleep_cap;

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	task automatic queue_event(input event_kind_t kind, input logic [2:0] slot,
		input logic [31:0] deadline, input logic found);
		sched_event_t ev;
		ev.kind     = kind;
		ev.slot     = slot;
		ev.deadline = deadline;
		ev.found    = found;
		ev.last     = 1'b0;
		due_events  = {due_events, ev};
	endtask

	task automatic free_timer(input int i);
		tm_active[i]  = 1'b0;
		tm_pending[i] = 1'b0;
		tm_paused[i]  = 1'b0;
		tm_stop[i]    = 1'b0;
	endtask

	// one request transaction: update the shadow table, queue the events it causes
	task automatic schedule_request(input logic [2:0] op, input logic [2:0] slot,
		input logic [31:0] now, input logic [31:0] period, input logic shut);
		int           base;
		logic         busy;
		logic [31:0]  next_dl;
		logic [31:0]  nearest;
		base = due_events.size();
		busy = tm_active[slot] | tm_pending[slot];
		case (op)
			OP_TICK: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (tm_pending[i]) begin
						tm_pending[i]  = 1'b0;
						tm_active[i]   = 1'b1;
						tm_deadline[i] = now;
					end
				end
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (tm_active[i]) begin
						if (tm_stop[i]) begin
							queue_event(EV_END, 3'(i), 32'd0, 1'b0);
							free_timer(i);
						end else if (!tm_paused[i] && tm_deadline[i] <= now) begin
							queue_event(EV_FIRE, 3'(i), 32'd0, 1'b0);
							next_dl = add_sat(tm_deadline[i], tm_period[i]);
							if (next_dl < now)
								next_dl = add_sat(now, tm_period[i]);
							tm_deadline[i] = next_dl;
						end
					end
				end
				nearest = add_sat(now, sleep_cap);
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (tm_active[i] && !tm_paused[i] && tm_deadline[i] < nearest)
						nearest = tm_deadline[i];
				end
				queue_event(EV_SUMMARY, 3'd0, nearest, 1'b0);
			end
			OP_ADD: begin
				if (!busy) begin
					free_timer(slot);
					tm_pending[slot]  = 1'b1;
					tm_period[slot]   = period;
					tm_deadline[slot] = 32'd0;
				end
			end
			OP_STOP: begin
				if (busy)
					tm_stop[slot] = 1'b1;
			end
			OP_STOP_ALL: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (shut) begin
						if (tm_active[i])
							queue_event(EV_END, 3'(i), 32'd0, 1'b0);
						free_timer(i);
					end else if (tm_active[i] || tm_pending[i]) begin
						tm_stop[i] = 1'b1;
					end
				end
			end
			OP_PAUSE: begin
				if (busy)
					tm_paused[slot] = 1'b1;
			end
			OP_RESUME: begin
				if (busy)
					tm_paused[slot] = 1'b0;
			end
			OP_QUERY: begin
				queue_event(EV_QUERY, slot, 32'd0, busy);
			end
			default: begin
			end
		endcase
		if (due_events.size() > base)
			due_events[due_events.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_event_t want;
		if (!arst_n) begin
			due_events.delete();
			tm_active   = '0;
			tm_pending  = '0;
			tm_paused   = '0;
			tm_stop     = '0;
			sleep_cap   = MAX_SLEEP_RESET;
			fail_cnt    = 0;
			pending_cnt = 0;
		end else begin
			// results first: an event taken at this edge belongs to an earlier request
			if (evt.valid && evt.ready) begin
				if (due_events.size() == 0) begin
					$display(
						"%0t: unexpected event kind %0d slot %0d deadline %0h found %0b last %0b",
						$time, evt.event_kind, evt.event_slot, evt.deadline_us,
						evt.found, evt.last);
					fail_cnt++;
				end else begin
					want = due_events[0];
					due_events.delete(0);
					if (evt.event_kind !== want.kind || evt.event_slot !== want.slot ||
						evt.deadline_us !== want.deadline || evt.found !== want.found ||
						evt.last !== want.last) begin
						$display(
							"%0t: event mismatch: expected kind %0d slot %0d deadline %0h found %0b last %0b",
							$time, want.kind, want.slot, want.deadline, want.found, want.last);
						$display(
							"%0t:                   actual kind %0d slot %0d deadline %0h found %0b last %0b",
							$time, evt.event_kind, evt.event_slot, evt.deadline_us,
							evt.found, evt.last);
						fail_cnt++;
					end
				end
			end
			if (cfg_we)
				sleep_cap = cfg_data;
			if (req.valid && req.ready)
				schedule_request(req.opcode, req.slot, req.now_us, req.period_us, req.shutdown);
			pending_cnt = due_events.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ptsch_pkg::*;

	localparam int NUM_TIMERS       = 8;
	// a tick walks NUM_TIMERS cells; keep a wide margin
	localparam int DRAIN_CYCLES     = 24;
	// worst quiet stretch: sender gap + full tick + receiver stall + drain, many times over
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_PER_PHASE = 62;
	// opcode value with no operation behind it
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_data;
	int          fail_cnt;
	int          pending_cnt;
	logic [31:0] cur_now;
	bit          tx_burst;
	bit          rx_burst;

	ptsch_req_if req_ch ();
	ptsch_evt_if evt_ch ();

	periodic_timer_scheduler #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_WIDTH(32)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.evt     (evt_ch),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	// watches both channels and the register port, predicts and compares
	ptsch_scoreboard #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_score (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.evt        (evt_ch),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.fail_cnt   (fail_cnt),
		.pending_cnt(pending_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: ends the run if neither channel moves a transaction for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Event receiver: ready changes on the falling edge. After each accepted
	// event it draws a random stall; burst stretches run with no stall.
	initial begin : event_sink
		int stall;
		stall = 0;
		rx_burst = 1'b0;
		evt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				evt_ch.ready <= 1'b0;
				stall--;
			end else begin
				evt_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (evt_ch.valid && evt_ch.ready) begin
				if ($urandom_range(0, 15) == 0)
					rx_burst = !rx_burst;
				stall = rx_burst ? 0 : $urandom_range(0, 10);
			end
		end
	end

	// One request transaction. Called right after an accepting edge (or at the
	// start), so valid is only ever written once per falling edge.
	task automatic send_req(input logic [2:0] op, input logic [2:0] slot,
		input logic [31:0] now, input logic [31:0] period, input logic shut);
		int gap;
		if ($urandom_range(0, 14) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= op;
		req_ch.slot      <= slot;
		req_ch.now_us    <= now;
		req_ch.period_us <= period;
		req_ch.shutdown  <= shut;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Hold off until every predicted event is out, then give work that
	// causes no event time to finish inside the block.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// max_sleep_us write; only called while the block is idle
	task automatic write_cfg(input logic [31:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Random traffic: mostly ticks on a slowly advancing clock and adds with
	// short periods, so slots keep firing; stops, pauses, queries and the odd
	// time jump or unused opcode mixed in. Unused fields carry random bits.
	task automatic run_random(input int count);
		int          pick;
		int          spread;
		logic [2:0]  op;
		logic [31:0] now;
		logic [31:0] period;
		logic        shut;
		for (int k = 0; k < count; k++) begin
			pick   = $urandom_range(0, 99);
			now    = $urandom();
			period = $urandom();
			shut   = $urandom_range(0, 1);
			if (pick < 40) begin
				op = OP_TICK;
				if ($urandom_range(0, 19) == 0)
					cur_now = $urandom();
				else
					cur_now = cur_now + $urandom_range(0, 20);
				now = cur_now;
			end else if (pick < 60) begin
				op = OP_ADD;
				spread = $urandom_range(0, 9);
				if (spread < 7)
					period = $urandom_range(0, 30);
				else if (spread < 9)
					period = $urandom_range(0, 1000);
			end else if (pick < 66) begin
				op = OP_STOP;
			end else if (pick < 70) begin
				op = OP_STOP_ALL;
				shut = ($urandom_range(0, 2) == 0);
			end else if (pick < 78) begin
				op = OP_PAUSE;
			end else if (pick < 86) begin
				op = OP_RESUME;
			end else if (pick < 97) begin
				op = OP_QUERY;
			end else begin
				op = OP_UNUSED;
			end
			send_req(op, 3'($urandom_range(0, 7)), now, period, shut);
			// occasional full hold-off with events still in flight
			if ($urandom_range(0, 49) == 0)
				settle();
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_data         = 32'd0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_TICK;
		req_ch.slot      = 3'd0;
		req_ch.now_us    = 32'd0;
		req_ch.period_us = 32'd0;
		req_ch.shutdown  = 1'b0;
		cur_now          = 32'd0;
		tx_burst         = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest cap first: summaries land at now + 1 unless a deadline is nearer
		write_cfg(32'd1);

		// directed: query of a free slot, adds at period extremes incl. zero,
		// add to a busy slot, commands on free slots, stop while pending
		send_req(OP_QUERY, 3'd0, $urandom(), $urandom(), 1'b0);
		send_req(OP_ADD, 3'd0, $urandom(), 32'd1, 1'b0);
		send_req(OP_ADD, 3'd7, $urandom(), 32'hFFFF_FFFF, 1'b1);
		send_req(OP_ADD, 3'd3, $urandom(), 32'd0, 1'b0);
		send_req(OP_ADD, 3'd0, $urandom(), 32'd50, 1'b0);
		send_req(OP_PAUSE, 3'd6, $urandom(), $urandom(), 1'b0);
		send_req(OP_ADD, 3'd5, $urandom(), 32'd10, 1'b0);
		send_req(OP_STOP, 3'd5, $urandom(), $urandom(), 1'b1);
		// activation tick: slot 5 ends at once, the rest fire
		send_req(OP_TICK, 3'd2, 32'd100, $urandom(), 1'b0);
		send_req(OP_QUERY, 3'd3, $urandom(), $urandom(), 1'b0);
		send_req(OP_PAUSE, 3'd3, $urandom(), $urandom(), 1'b0);
		send_req(OP_TICK, 3'd5, 32'd101, $urandom(), 1'b1);
		send_req(OP_RESUME, 3'd3, $urandom(), $urandom(), 1'b0);
		// big jump: slot 0 deadline falls behind, slot 7 saturates
		send_req(OP_TICK, 3'd7, 32'hFFFF_0000, $urandom(), 1'b0);
		send_req(OP_TICK, 3'd1, 32'hFFFF_FFFF, $urandom(), 1'b0);
		send_req(OP_UNUSED, 3'd4, $urandom(), $urandom(), 1'b1);
		// stop all without shutdown: marks only, ends come with the next tick
		send_req(OP_STOP_ALL, 3'd0, $urandom(), $urandom(), 1'b0);
		send_req(OP_ADD, 3'd1, $urandom(), 32'd5, 1'b0);
		send_req(OP_TICK, 3'd6, 32'd0, $urandom(), 1'b0);
		send_req(OP_ADD, 3'd2, $urandom(), 32'd7, 1'b0);
		send_req(OP_RESUME, 3'd4, $urandom(), $urandom(), 1'b0);
		send_req(OP_STOP, 3'd6, $urandom(), $urandom(), 1'b0);
		send_req(OP_TICK, 3'd3, 32'd3, $urandom(), 1'b0);
		// pending slot 6 is dropped by the shutdown without an event
		send_req(OP_ADD, 3'd6, $urandom(), 32'd9, 1'b0);
		send_req(OP_STOP_ALL, 3'd7, $urandom(), $urandom(), 1'b1);
		send_req(OP_QUERY, 3'd6, $urandom(), $urandom(), 1'b1);

		cur_now = 32'd1000;
		settle();
		write_cfg(32'hFFFF_FFFF);
		run_random(RANDOM_PER_PHASE);
		settle();
		write_cfg($urandom_range(1, 300));
		run_random(RANDOM_PER_PHASE);
		settle();
		write_cfg($urandom() | 32'd1);
		run_random(RANDOM_PER_PHASE);
		settle();
		write_cfg(MAX_SLEEP_RESET);
		run_random(RANDOM_PER_PHASE);

		// end of run: all events out plus drain time, watchdog bounds the wait
		settle();
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
